>>> src/ilu_pkg.sv
// Shared types and constants for the image line unfilter.
// Depends on nothing; the regs, front, back and top files and the testbench import it.
package ilu_pkg;

  // Filter codes carried with each byte of a line.
  localparam logic [7:0] FILT_NONE  = 8'd0;
  localparam logic [7:0] FILT_SUB   = 8'd1;
  localparam logic [7:0] FILT_UP    = 8'd2;
  localparam logic [7:0] FILT_AVG   = 8'd3;
  localparam logic [7:0] FILT_PAETH = 8'd4;

  // Register word indexes on the configuration port.
  localparam logic REG_BPP  = 1'b0;
  localparam logic REG_LINE = 1'b1;

  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 32;
  localparam int BppW     = 3;
  localparam int LineW    = 14;

  // Operation decided by the front part; sub, avg and Paeth fold to none with no left byte.
  typedef enum logic [2:0] {
    MODE_NONE,
    MODE_SUB,
    MODE_UP,
    MODE_AVG,
    MODE_PAETH
  } mode_t;

  // Per-byte control handed from the front part to the back part.
  typedef struct packed {
    logic [7:0] data;
    mode_t      mode;
    logic       upper_zero;
    logic       last;
  } item_ctl_t;

  // Configuration registers as seen by the datapath.
  typedef struct packed {
    logic [BppW-1:0]  bytes_per_pixel;
    logic [LineW-1:0] line_bytes;
  } cfg_t;

endpackage

>>> src/ilu_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module ilu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Read port; data is held until the next enabled read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

endmodule

>>> src/ilu_queue.sv
// Small register queue used between the parts of the unfilter and at its output.
// Depends on nothing.
module ilu_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] wdata,
  output logic              full,
  input  logic              pop,
  output logic [DATA_W-1:0] rdata,
  output logic              valid
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]       count_r, count_nxt;
  logic              do_push, do_pop;

  assign full    = (count_r == (AW+1)'(DEPTH));
  assign valid   = (count_r != '0);
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  // Pointer and fill count updates, wrapping at the queue depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + (AW+1)'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage takes each accepted transfer.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

>>> src/ilu_regs.sv
// APB-style configuration registers of the unfilter.
// Depends on ilu_pkg for register indexes and the configuration struct.
module ilu_regs
  import ilu_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg
);

  logic [BppW-1:0]  bpp_r;
  logic [LineW-1:0] line_bytes_r;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register writes, decoded on the word index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r        <= BppW'(1);
      line_bytes_r <= LineW'(1024);
    end else if (wr_en) begin
      case (paddr[2])
        REG_BPP:  bpp_r        <= pwdata[BppW-1:0];
        REG_LINE: line_bytes_r <= pwdata[LineW-1:0];
        default:  bpp_r        <= bpp_r;
      endcase
    end
  end

  // Read-back multiplexer.
  always_comb begin
    case (paddr[2])
      REG_BPP:  prdata = CfgDataW'(bpp_r);
      REG_LINE: prdata = CfgDataW'(line_bytes_r);
      default:  prdata = '0;
    endcase
  end

  assign cfg.bytes_per_pixel = bpp_r;
  assign cfg.line_bytes      = line_bytes_r;

endmodule

>>> src/ilu_front.sv
// Front part: tracks line position and row, and classifies each accepted byte.
// Depends on ilu_pkg for filter codes, modes and the control struct.
module ilu_front
  import ilu_pkg::*;
#(
  parameter int MAX_LINE_BYTES = 8192,
  parameter int MAX_BPP        = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              accept,
  input  logic [7:0]                        filtered_byte,
  input  logic [7:0]                        filter_code,
  input  logic                              image_start,
  input  cfg_t                              cfg,
  output item_ctl_t                         ctl,
  output logic [$clog2(MAX_LINE_BYTES)-1:0] col,
  output logic [((MAX_BPP > 1) ? $clog2(MAX_BPP) : 1)-1:0] bpp_idx
);

  localparam int CW   = $clog2(MAX_LINE_BYTES);
  localparam int BW   = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1;
  localparam int LENW = (CW + 1 > LineW) ? CW + 1 : LineW;

  logic [CW-1:0]   column_r, column_nxt;
  logic            first_row_r, first_row_nxt;
  logic [3:0]      bpp_eff;
  logic [LENW-1:0] len_eff;
  logic            first_cur;
  logic            has_left;
  logic            last;

  // Clamp the pixel size and line length to their usable ranges.
  always_comb begin
    bpp_eff = {1'b0, cfg.bytes_per_pixel};
    if (bpp_eff == 4'd0) begin
      bpp_eff = 4'd1;
    end else if (bpp_eff > 4'(MAX_BPP)) begin
      bpp_eff = 4'(MAX_BPP);
    end
    len_eff = LENW'(cfg.line_bytes);
    if (len_eff == '0) begin
      len_eff = LENW'(1);
    end else if (len_eff > LENW'(MAX_LINE_BYTES)) begin
      len_eff = LENW'(MAX_LINE_BYTES);
    end
  end

  // Position of this byte; an image start restarts at the first column.
  assign col       = image_start ? '0 : column_r;
  assign first_cur = image_start || first_row_r;
  assign has_left  = (LENW'(col) >= LENW'(bpp_eff));
  assign last      = ((LENW'(col) + LENW'(1)) >= len_eff);
  assign bpp_idx   = BW'(bpp_eff - 4'd1);

  // Filter decode; sub, average and Paeth bytes without a left neighbour pass unchanged.
  always_comb begin
    ctl.data       = filtered_byte;
    ctl.upper_zero = first_cur;
    ctl.last       = last;
    case (filter_code)
      FILT_SUB:   ctl.mode = has_left ? MODE_SUB : MODE_NONE;
      FILT_UP:    ctl.mode = MODE_UP;
      FILT_AVG:   ctl.mode = has_left ? MODE_AVG : MODE_NONE;
      FILT_PAETH: ctl.mode = has_left ? MODE_PAETH : MODE_NONE;
      default:    ctl.mode = MODE_NONE;
    endcase
  end

  // Line position advance on each accepted transfer.
  always_comb begin
    column_nxt    = column_r;
    first_row_nxt = first_row_r;
    if (accept) begin
      column_nxt    = last ? '0 : col + CW'(1);
      first_row_nxt = last ? 1'b0 : first_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r    <= '0;
      first_row_r <= 1'b1;
    end else begin
      column_r    <= column_nxt;
      first_row_r <= first_row_nxt;
    end
  end

endmodule

>>> src/ilu_back.sv
// Back part: reads the prior line, reconstructs each byte and stores it back.
// Depends on ilu_pkg and instantiates ilu_ram for the prior line.
module ilu_back
  import ilu_pkg::*;
#(
  parameter int MAX_LINE_BYTES = 8192,
  parameter int MAX_BPP        = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              head_valid,
  input  item_ctl_t                         head_ctl,
  input  logic [$clog2(MAX_LINE_BYTES)-1:0] head_col,
  input  logic [((MAX_BPP > 1) ? $clog2(MAX_BPP) : 1)-1:0] head_bpp_idx,
  output logic                              head_pop,
  input  logic                              res_full,
  output logic                              res_push,
  output logic [7:0]                        res_byte,
  output logic                              res_line_end
);

  localparam int CW = $clog2(MAX_LINE_BYTES);
  localparam int BW = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1;

  logic            ex_valid_r, ex_valid_nxt;
  item_ctl_t       ex_ctl_r;
  logic [CW-1:0]   ex_col_r;
  logic [BW-1:0]   ex_bidx_r;
  logic            fwd_hit_r;
  logic [7:0]      fwd_data_r;
  logic [7:0]      left_r [MAX_BPP];
  logic [7:0]      upleft_r [MAX_BPP];
  logic [7:0]      ram_rdata;
  logic            ex_adv;
  logic            load;
  logic [7:0]      a_val, b_val, c_val, add_val, r_val;
  logic [8:0]      avg_sum;

  // Paeth predictor: nearest of a, b, c to a+b-c, ties to a then b.
  function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
    logic signed [10:0] pa, pb, pc;
    logic [7:0]         pick;
    pa = $signed({3'b000, b}) - $signed({3'b000, c});
    pb = $signed({3'b000, a}) - $signed({3'b000, c});
    pc = pa + pb;
    if (pa < 0) pa = -pa;
    if (pb < 0) pb = -pb;
    if (pc < 0) pc = -pc;
    if (pa <= pb && pa <= pc) begin
      pick = a;
    end else if (pb <= pc) begin
      pick = b;
    end else begin
      pick = c;
    end
    return pick;
  endfunction

  // Execute slot advances into the result queue; a new byte loads behind it.
  assign ex_adv   = ex_valid_r && !res_full;
  assign load     = head_valid && (!ex_valid_r || ex_adv);
  assign head_pop = load;

  always_comb begin
    ex_valid_nxt = ex_valid_r;
    if (load) begin
      ex_valid_nxt = 1'b1;
    end else if (ex_adv) begin
      ex_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_valid_r <= 1'b0;
    end else begin
      ex_valid_r <= ex_valid_nxt;
    end
  end

  // Byte loaded into the execute slot; the prior-line read starts at the same edge.
  // When the byte leaving writes the same column, its result is forwarded.
  always_ff @(posedge clk) begin
    if (load) begin
      ex_ctl_r   <= head_ctl;
      ex_col_r   <= head_col;
      ex_bidx_r  <= head_bpp_idx;
      fwd_hit_r  <= ex_adv && (ex_col_r == head_col);
      fwd_data_r <= r_val;
    end
  end

  ilu_ram #(
    .WIDTH (8),
    .DEPTH (MAX_LINE_BYTES)
  ) u_prior_line (
    .clk     (clk),
    .we      (ex_adv),
    .waddr   (ex_col_r),
    .wdata   (r_val),
    .re      (load),
    .raddr   (head_col),
    .rdata_r (ram_rdata)
  );

  // Neighbour bytes: upper from the prior line, left and upper-left from windows.
  assign b_val   = ex_ctl_r.upper_zero ? 8'd0 : (fwd_hit_r ? fwd_data_r : ram_rdata);
  assign a_val   = left_r[ex_bidx_r];
  assign c_val   = upleft_r[ex_bidx_r];
  assign avg_sum = {1'b0, a_val} + {1'b0, b_val};

  // Reconstruction, modulo 256.
  always_comb begin
    case (ex_ctl_r.mode)
      MODE_SUB:   add_val = a_val;
      MODE_UP:    add_val = b_val;
      MODE_AVG:   add_val = avg_sum[8:1];
      MODE_PAETH: add_val = paeth_pick(a_val, b_val, c_val);
      default:    add_val = 8'd0;
    endcase
    r_val = ex_ctl_r.data + add_val;
  end

  // Sliding windows of recent results and upper bytes, newest at index zero.
  always_ff @(posedge clk) begin
    if (ex_adv) begin
      for (int i = 0; i < MAX_BPP; i++) begin
        if (i == 0) begin
          left_r[i]   <= r_val;
          upleft_r[i] <= b_val;
        end else begin
          left_r[i]   <= left_r[i-1];
          upleft_r[i] <= upleft_r[i-1];
        end
      end
    end
  end

  assign res_push     = ex_adv;
  assign res_byte     = r_val;
  assign res_line_end = ex_ctl_r.last;

endmodule

>>> src/image_line_unfilter_top.sv
// Image line unfilter: one reconstructed byte per accepted filtered byte.
// An accepted byte passes the work queue and the execute slot into the result queue.
// Throughput: one byte per cycle unless the result side stalls, set by the prior-line
// RAM read and the left-neighbour feedback through the execute slot.
// Reset clears the queues and line position and presets the registers; the prior-line
// RAM is not cleared, the first row of each image reads its upper bytes as zero.
module image_line_unfilter_top
  import ilu_pkg::*;
#(
  parameter int MAX_LINE_BYTES = 8192,
  parameter int MAX_BPP        = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  logic [7:0]          in_filtered_byte,
  input  logic [7:0]          in_filter_code,
  input  logic                in_image_start,
  output logic                empty,
  input  logic                pop,
  output logic [7:0]          out_pixel_byte,
  output logic                out_line_end,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  localparam int CW     = $clog2(MAX_LINE_BYTES);
  localparam int BW     = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1;
  localparam int CTL_W  = $bits(item_ctl_t);
  localparam int DESC_W = CTL_W + CW + BW;

  cfg_t              cfg;
  item_ctl_t         fr_ctl, hd_ctl;
  logic [CW-1:0]     fr_col, hd_col;
  logic [BW-1:0]     fr_bidx, hd_bidx;
  logic [DESC_W-1:0] q_wdata, q_rdata;
  logic              q_valid, q_pop;
  logic              accept;
  logic              res_full, res_push, res_valid, res_line_end;
  logic [7:0]        res_byte;
  logic [8:0]        res_rdata;

  assign accept = push && !full;

  ilu_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ilu_front #(
    .MAX_LINE_BYTES (MAX_LINE_BYTES),
    .MAX_BPP        (MAX_BPP)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .filtered_byte (in_filtered_byte),
    .filter_code   (in_filter_code),
    .image_start   (in_image_start),
    .cfg           (cfg),
    .ctl           (fr_ctl),
    .col           (fr_col),
    .bpp_idx       (fr_bidx)
  );

  // Decoupling queue between the front and back parts.
  assign q_wdata = {fr_ctl, fr_col, fr_bidx};

  ilu_queue #(
    .DATA_W (DESC_W),
    .DEPTH  (2)
  ) u_work_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (q_wdata),
    .full  (full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .valid (q_valid)
  );

  assign hd_ctl  = item_ctl_t'(q_rdata[DESC_W-1 -: CTL_W]);
  assign hd_col  = q_rdata[BW +: CW];
  assign hd_bidx = q_rdata[BW-1:0];

  ilu_back #(
    .MAX_LINE_BYTES (MAX_LINE_BYTES),
    .MAX_BPP        (MAX_BPP)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_valid   (q_valid),
    .head_ctl     (hd_ctl),
    .head_col     (hd_col),
    .head_bpp_idx (hd_bidx),
    .head_pop     (q_pop),
    .res_full     (res_full),
    .res_push     (res_push),
    .res_byte     (res_byte),
    .res_line_end (res_line_end)
  );

  // Result queue; parts the back part from the consumer's stalls.
  ilu_queue #(
    .DATA_W (9),
    .DEPTH  (2)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata ({res_line_end, res_byte}),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rdata),
    .valid (res_valid)
  );

  assign empty          = !res_valid;
  assign out_pixel_byte = res_rdata[7:0];
  assign out_line_end   = res_rdata[8];

endmodule

>>> sim/testbench.sv
// Self-checking testbench for image_line_unfilter_top: a directed table, then random lines,
// checked byte by byte against typed table bytes or a behavioural unfilter in this file.
// Depends on ilu_pkg and the RTL under src; it needs no other file.
module testbench;
  import ilu_pkg::*;

  localparam int MAX_LINE_BYTES = 8192;
  localparam int MAX_BPP        = 4;
  localparam int SETTLE_CYCLES  = 4;
  localparam int HOLD_CYCLES    = 200;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int DIRECTED_ROWS  = 22;

  // Codes outside the defined set, which must behave as no filter.
  localparam logic [7:0] FILT_FIRST_UNUSED = 8'd5;
  localparam logic [7:0] FILT_TOP_UNUSED   = 8'hFF;

  // Register reset values.
  localparam logic [BppW-1:0]  BPP_AT_RESET  = 3'd1;
  localparam logic [LineW-1:0] LINE_AT_RESET = 14'd1024;

  // Whether a directed row carries its own expected byte.
  localparam logic TYPED     = 1'b1;
  localparam logic PREDICTED = 1'b0;

  typedef struct packed {
    logic [7:0] fbyte;
    logic [7:0] code;
    logic       start;
    logic       typed;
    logic [7:0] want_byte;
    logic       want_end;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic       line_end;
  } pixel_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                push = 1'b0;
  logic [7:0]          in_filtered_byte = '0;
  logic [7:0]          in_filter_code = '0;
  logic                in_image_start = 1'b0;
  logic                pop = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [CfgDataW-1:0] pwdata = '0;
  logic                full;
  logic                empty;
  logic [7:0]          out_pixel_byte;
  logic                out_line_end;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  image_line_unfilter_top #(
    .MAX_LINE_BYTES(MAX_LINE_BYTES),
    .MAX_BPP       (MAX_BPP)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_filtered_byte(in_filtered_byte),
    .in_filter_code  (in_filter_code),
    .in_image_start  (in_image_start),
    .empty           (empty),
    .pop             (pop),
    .out_pixel_byte  (out_pixel_byte),
    .out_line_end    (out_line_end),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // Behavioural copy of the unfilter state and its registers.
  logic [7:0]       prior_row [MAX_LINE_BYTES];
  logic [7:0]       left_win [MAX_BPP];
  logic [7:0]       upper_left_win [MAX_BPP];
  int               column = 0;
  logic             first_row = 1'b1;
  int               prior_valid = 0;
  logic [BppW-1:0]  cfg_bpp = BPP_AT_RESET;
  logic [LineW-1:0] cfg_line = LINE_AT_RESET;
  logic [7:0]       line_code = FILT_NONE;

  pixel_t    pixels_due [$];
  stim_row_t directed [DIRECTED_ROWS];
  int        mismatches = 0;
  int        cycle_count = 0;
  int        gap_max = 12;
  logic      burst = 1'b0;
  logic      held = 1'b0;

  initial begin
    forever #6 clk = ~clk;
  end

  // Guard against a hung run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL image_line_unfilter_top");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch in %s: got 0x%0h, want 0x%0h", what, got, want);
    mismatches++;
  endtask

  function automatic logic [7:0] paeth_choice(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
    int p, da, db, dc;
    p  = int'(a) + int'(b) - int'(c);
    da = (p > int'(a)) ? p - int'(a) : int'(a) - p;
    db = (p > int'(b)) ? p - int'(b) : int'(b) - p;
    dc = (p > int'(c)) ? p - int'(c) : int'(c) - p;
    if (da <= db && da <= dc) return a;
    if (db <= dc) return b;
    return c;
  endfunction

  // Reconstructs one byte and advances the line position.
  task automatic unfilter_byte(input logic [7:0] x, input logic [7:0] code, input logic start,
                               output logic [7:0] r, output logic last);
    int   bpp, len, add, i;
    logic has_left;
    logic [7:0] a, b, c;
    bpp = cfg_bpp;
    len = cfg_line;
    if (bpp == 0) bpp = 1;
    if (bpp > MAX_BPP) bpp = MAX_BPP;
    if (len == 0) len = 1;
    if (len > MAX_LINE_BYTES) len = MAX_LINE_BYTES;
    if (start) begin
      column = 0;
      first_row = 1'b1;
      for (i = 0; i < MAX_BPP; i++) begin
        left_win[i] = '0;
        upper_left_win[i] = '0;
      end
    end
    if (column >= MAX_LINE_BYTES) column = MAX_LINE_BYTES - 1;
    has_left = (column >= bpp);
    b = first_row ? 8'd0 : prior_row[column];
    a = has_left ? left_win[bpp-1] : 8'd0;
    c = has_left ? upper_left_win[bpp-1] : 8'd0;
    case (code)
      FILT_SUB:   add = has_left ? int'(a) : 0;
      FILT_UP:    add = int'(b);
      FILT_AVG:   add = has_left ? (int'(a) + int'(b)) / 2 : 0;
      FILT_PAETH: add = has_left ? int'(paeth_choice(a, b, c)) : 0;
      default:    add = 0;
    endcase
    r = 8'((int'(x) + add) & 255);
    for (i = MAX_BPP - 1; i > 0; i--) begin
      left_win[i] = left_win[i-1];
      upper_left_win[i] = upper_left_win[i-1];
    end
    left_win[0] = r;
    upper_left_win[0] = b;
    prior_row[column] = r;
    // Columns always run up from zero, so the written part of the row is a prefix.
    if (column == prior_valid) prior_valid = column + 1;
    last = (column + 1 >= len);
    if (last) begin
      column = 0;
      first_row = 1'b0;
      for (i = 0; i < MAX_BPP; i++) begin
        left_win[i] = '0;
        upper_left_win[i] = '0;
      end
    end else begin
      column++;
    end
  endtask

  // Offers one byte after a random gap and records its expected result on transfer.
  task automatic offer_byte(input stim_row_t item);
    int         gap;
    logic [7:0] r;
    logic       last;
    gap = (gap_max == 0) ? 0 : $urandom_range(gap_max, 0);
    repeat (gap) begin
      @(negedge clk);
      push <= 1'b0;
    end
    @(negedge clk);
    push             <= 1'b1;
    in_filtered_byte <= item.fbyte;
    in_filter_code   <= item.code;
    in_image_start   <= item.start;
    do @(posedge clk); while (full !== 1'b0);
    unfilter_byte(item.fbyte, item.code, item.start, r, last);
    if (item.typed) pixels_due.push_back('{item.want_byte, item.want_end});
    else pixels_due.push_back('{r, last});
  endtask

  // One configuration-port transfer: a setup phase, then an access phase until pready.
  task automatic cfg_access(input logic wr, input logic [CfgAddrW-1:0] addr,
                            input logic [CfgDataW-1:0] wdata,
                            output logic [CfgDataW-1:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Stops offering and waits until every pending byte has been taken out.
  task automatic drain;
    @(negedge clk);
    push <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes both registers with junk in the unused bits, then reads them back.
  task automatic set_config(input logic [BppW-1:0] bpp_val, input logic [LineW-1:0] line_val);
    logic [CfgDataW-1:0] rd;
    drain();
    cfg_access(1'b1, {REG_BPP, 2'b00}, ($urandom() & ~32'h7) | 32'(bpp_val), rd);
    cfg_bpp = bpp_val;
    cfg_access(1'b1, {REG_LINE, 2'b00}, ($urandom() & ~32'h3FFF) | 32'(line_val), rd);
    cfg_line = line_val;
    cfg_access(1'b0, {REG_BPP, 2'b00}, '0, rd);
    if (rd !== 32'(bpp_val)) report_mismatch("bytes_per_pixel readback", rd, 32'(bpp_val));
    cfg_access(1'b0, {REG_LINE, 2'b00}, '0, rd);
    if (rd !== 32'(line_val)) report_mismatch("line_bytes readback", rd, 32'(line_val));
  endtask

  // Random lines: one filter code per line, rare image starts, some stray codes.
  task automatic stream_random(input int count);
    stim_row_t item;
    int        n, pick;
    for (n = 0; n < count; n++) begin
      item.start = ($urandom_range(49, 0) == 0);
      // A row never written since reset must not be read as the upper line.
      if (!first_row && column >= prior_valid) item.start = 1'b1;
      if (item.start || column == 0) begin
        line_code = ($urandom_range(9, 0) == 0) ? 8'($urandom_range(255, 5))
                                                 : 8'($urandom_range(4, 0));
      end
      item.code = ($urandom_range(19, 0) == 0) ? 8'($urandom_range(255, 0)) : line_code;
      pick = $urandom_range(7, 0);
      item.fbyte = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom_range(255, 0));
      item.typed = PREDICTED;
      item.want_byte = '0;
      item.want_end = 1'b0;
      offer_byte(item);
    end
  endtask

  // Result side: random pops, one long hold-off during the burst phase.
  initial begin
    int     gap;
    pixel_t want;
    @(posedge rst_n);
    forever begin
      if (burst && !held) begin
        held = 1'b1;
        @(negedge clk);
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = (gap_max == 0) ? 0 : $urandom_range(gap_max, 0);
      repeat (gap) begin
        @(negedge clk);
        pop <= 1'b0;
      end
      @(negedge clk);
      pop <= 1'b1;
      do @(posedge clk); while (empty !== 1'b0);
      if (pixels_due.size() == 0) begin
        report_mismatch("result with nothing pending", 32'(out_pixel_byte), '0);
      end else begin
        want = pixels_due.pop_front();
        if (out_pixel_byte !== want.pixel)
          report_mismatch("pixel_byte", 32'(out_pixel_byte), 32'(want.pixel));
        if (out_line_end !== want.line_end)
          report_mismatch("line_end", 32'(out_line_end), 32'(want.line_end));
      end
    end
  end

  // Main sequence: reset, register check, directed table, random phases.
  initial begin
    logic [CfgDataW-1:0] rd;
    int i;
    for (i = 0; i < MAX_BPP; i++) begin
      left_win[i] = '0;
      upper_left_win[i] = '0;
    end

    // Pixel size two, four bytes per line; three lines, then a fresh image mid-line.
    directed[0]  = {8'hFF, FILT_SUB,          1'b1, TYPED,     8'hFF, 1'b0};
    directed[1]  = {8'h01, FILT_SUB,          1'b0, TYPED,     8'h01, 1'b0};
    directed[2]  = {8'h01, FILT_SUB,          1'b0, TYPED,     8'h00, 1'b0};
    directed[3]  = {8'hFF, FILT_UP,           1'b0, TYPED,     8'hFF, 1'b1};
    directed[4]  = {8'h01, FILT_UP,           1'b0, TYPED,     8'h00, 1'b0};
    directed[5]  = {8'h00, FILT_AVG,          1'b0, TYPED,     8'h00, 1'b0};
    directed[6]  = {8'h10, FILT_AVG,          1'b0, PREDICTED, 8'h00, 1'b0};
    directed[7]  = {8'h05, FILT_PAETH,        1'b0, PREDICTED, 8'h00, 1'b0};
    directed[8]  = {8'h80, FILT_TOP_UNUSED,   1'b0, TYPED,     8'h80, 1'b0};
    directed[9]  = {8'h7F, FILT_FIRST_UNUSED, 1'b0, TYPED,     8'h7F, 1'b0};
    directed[10] = {8'h00, FILT_PAETH,        1'b0, PREDICTED, 8'h00, 1'b0};
    directed[11] = {8'hFF, FILT_PAETH,        1'b0, PREDICTED, 8'h00, 1'b0};
    directed[12] = {8'h44, FILT_NONE,         1'b0, TYPED,     8'h44, 1'b0};
    directed[13] = {8'h55, FILT_SUB,          1'b0, TYPED,     8'h55, 1'b0};
    directed[14] = {8'h33, FILT_UP,           1'b1, TYPED,     8'h33, 1'b0};
    directed[15] = {8'h00, FILT_SUB,          1'b0, TYPED,     8'h00, 1'b0};
    directed[16] = {8'h01, FILT_SUB,          1'b0, TYPED,     8'h34, 1'b0};
    directed[17] = {8'hFF, FILT_AVG,          1'b0, TYPED,     8'hFF, 1'b1};
    directed[18] = {8'h00, FILT_PAETH,        1'b0, TYPED,     8'h00, 1'b0};
    directed[19] = {8'h00, FILT_UP,           1'b0, PREDICTED, 8'h00, 1'b0};
    directed[20] = {8'h00, FILT_PAETH,        1'b0, PREDICTED, 8'h00, 1'b0};
    directed[21] = {8'h12, FILT_AVG,          1'b0, PREDICTED, 8'h00, 1'b0};

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    cfg_access(1'b0, {REG_BPP, 2'b00}, '0, rd);
    if (rd !== 32'(BPP_AT_RESET)) report_mismatch("bytes_per_pixel at reset", rd, 32'(BPP_AT_RESET));
    cfg_access(1'b0, {REG_LINE, 2'b00}, '0, rd);
    if (rd !== 32'(LINE_AT_RESET)) report_mismatch("line_bytes at reset", rd, 32'(LINE_AT_RESET));

    set_config(3'd2, 14'd4);
    for (i = 0; i < DIRECTED_ROWS; i++) offer_byte(directed[i]);

    set_config(3'd1, 14'd1);
    stream_random(40);
    // Zero sizes act as one.
    set_config(3'd0, 14'd0);
    stream_random(30);
    set_config(3'd3, 14'd5);
    stream_random(80);
    // A stretch with no idling on either side.
    set_config(3'd4, 14'd7);
    gap_max = 0;
    stream_random(80);
    gap_max = 12;
    // Both registers above their limits saturate.
    set_config(3'd7, 14'd16383);
    stream_random(40);
    // Back-to-back bytes while the result side holds off, so the input stalls.
    set_config(3'd2, 14'd12);
    gap_max = 0;
    burst = 1'b1;
    stream_random(100);
    burst = 1'b0;
    gap_max = 12;
    // Shorter line than the current column: the next byte ends the line.
    set_config(3'd4, 14'd3);
    stream_random(60);
    set_config(3'd6, 14'd33);
    stream_random(120);
    set_config(3'd1, 14'($urandom_range(40, 1)));
    stream_random(100);
    set_config(3'd2, 14'd16);
    stream_random(100);

    drain();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS image_line_unfilter_top");
    end else begin
      $display("FAIL image_line_unfilter_top");
    end
    $finish;
  end

endmodule

>>> files.f
src/ilu_pkg.sv
src/ilu_ram.sv
src/ilu_queue.sv
src/ilu_regs.sv
src/ilu_front.sv
src/ilu_back.sv
src/image_line_unfilter_top.sv
sim/testbench.sv
